[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Item, result and command records, decoder modes, status codes and the
// UTF-8 length and byte helpers used by the front and back parts.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int LENGTH_WIDTH = 16;
   localparam int CP_WIDTH     = 21;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
   localparam logic [CP_WIDTH-1:0] SUPP_BASE = 21'h10000;

   typedef enum logic [2:0] {
      MODE_PLAIN   = 3'd0,
      MODE_ESC     = 3'd1,
      MODE_HEX     = 3'd2,
      MODE_HIGH    = 3'd3,
      MODE_HIGH_BS = 3'd4,
      MODE_LOW_HEX = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_CUT_ESCAPE   = 3'd1,
      STATUS_CUT_UNICODE  = 3'd2,
      STATUS_BAD_HEX      = 3'd3,
      STATUS_LONE_LOW     = 3'd4,
      STATUS_BAD_ESCAPE   = 3'd5,
      STATUS_CONTROL      = 3'd6,
      STATUS_UNTERMINATED = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        string_done;
      logic [2:0]  status;
      logic [15:0] decoded_length;
      logic        last;
   } rsp_type;

   // work for the back part: optional first code point (held high surrogate
   // or combined pair), optional second one (raw byte or code point), done
   typedef struct packed {
      logic                a_valid;
      logic [CP_WIDTH-1:0] a_cp;
      logic                b_valid;
      logic                b_raw;
      logic [CP_WIDTH-1:0] b_cp;
      logic                done;
      logic [2:0]          status;
      logic [15:0]         length;
   } cmd_type;

   function automatic logic [2:0] utf8_len(input logic [CP_WIDTH-1:0] cp);
      logic [2:0] n;
      if (cp <= 21'h7F)         n = 3'd1;
      else if (cp <= 21'h7FF)   n = 3'd2;
      else if (cp <= 21'hFFFF)  n = 3'd3;
      else                      n = 3'd4;
      return n;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [CP_WIDTH-1:0] cp,
                                            input logic [2:0] n,
                                            input logic [2:0] k);
      logic [7:0] b;
      b = cp[7:0];
      case (n)
         3'd2: begin
            case (k)
               3'd0:    b = {3'b110, cp[10:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd3: begin
            case (k)
               3'd0:    b = {4'b1110, cp[15:12]};
               3'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (k)
               3'd0:    b = {5'b11110, cp[20:18]};
               3'd1:    b = {2'b10, cp[17:12]};
               3'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = cp[7:0];
      endcase
      return b;
   endfunction

endpackage

[rtl/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Runs the escape state machine on each accepted byte and turns it into at
// most one command for the back part, keeping the running output length.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  jsu_pkg::req_type  req,
   output jsu_pkg::cmd_type  cmd,
   output logic              cmd_valid
);

   localparam int LW = jsu_pkg::LENGTH_WIDTH;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   localparam logic [LW+2:0] COUNT_MAX = (LW+3)'({LW{1'b1}});

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      if (c >= 8'h30 && c <= 8'h39)      v = c[3:0];
      else if (is_hex(c))                v = c[3:0] + 4'd9;
      else                               v = 4'd0;
      return v;
   endfunction

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [15:0]   acc_ff, acc_in;
   logic [2:0]    dc_ff, dc_in;
   logic          bad_ff, bad_in;
   logic [9:0]    high_ff, high_in;
   logic [LW-1:0] count_ff, count_in;

   logic [7:0]    c;
   logic [15:0]   acc_t;
   logic [2:0]    dc_t;
   logic          bad_t;
   logic [jsu_pkg::CP_WIDTH-1:0] flush_cp;
   logic          run_plain, run_esc, run_hex_done, finish;
   jsu_pkg::status_type fin_status;
   logic [2:0]    na, nb;
   logic [LW+2:0] sum;
   logic [LW-1:0] sat_count;
   logic [31:0]   sat_wide;

   always_comb begin
      c          = req.data_byte;
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      dc_in      = dc_ff;
      bad_in     = bad_ff;
      high_in    = high_ff;
      cmd        = '0;
      run_plain  = 1'b0;
      run_esc    = 1'b0;
      run_hex_done = 1'b0;
      finish     = 1'b0;
      fin_status = jsu_pkg::STATUS_OK;
      acc_t      = {acc_ff[11:0], hex_val(c)};
      dc_t       = dc_ff + 3'd1;
      bad_t      = bad_ff | ~is_hex(c);
      flush_cp   = {5'b0, 6'b110110, high_ff};

      if (req.end_of_input) begin
         finish = 1'b1;
         unique case (mode_ff)
            jsu_pkg::MODE_ESC: fin_status = jsu_pkg::STATUS_CUT_ESCAPE;
            jsu_pkg::MODE_HEX: fin_status = jsu_pkg::STATUS_CUT_UNICODE;
            jsu_pkg::MODE_HIGH: begin
               cmd.a_valid = 1'b1;
               cmd.a_cp    = flush_cp;
               fin_status  = jsu_pkg::STATUS_UNTERMINATED;
            end
            jsu_pkg::MODE_HIGH_BS: begin
               cmd.a_valid = 1'b1;
               cmd.a_cp    = flush_cp;
               fin_status  = jsu_pkg::STATUS_CUT_ESCAPE;
            end
            jsu_pkg::MODE_LOW_HEX: begin
               cmd.a_valid = 1'b1;
               cmd.a_cp    = flush_cp;
               fin_status  = jsu_pkg::STATUS_CUT_UNICODE;
            end
            default: fin_status = jsu_pkg::STATUS_UNTERMINATED;
         endcase
      end else begin
         unique case (mode_ff)
            jsu_pkg::MODE_ESC: run_esc = 1'b1;
            jsu_pkg::MODE_HEX: begin
               acc_in = acc_t;
               dc_in  = dc_t;
               bad_in = bad_t;
               if (dc_t >= 3'd4) run_hex_done = 1'b1;
            end
            jsu_pkg::MODE_HIGH: begin
               if (c == CHAR_BSLASH) begin
                  mode_in = jsu_pkg::MODE_HIGH_BS;
               end else begin
                  cmd.a_valid = 1'b1;
                  cmd.a_cp    = flush_cp;
                  run_plain   = 1'b1;
               end
            end
            jsu_pkg::MODE_HIGH_BS: begin
               if (c == CHAR_U) begin
                  mode_in = jsu_pkg::MODE_LOW_HEX;
                  acc_in  = '0;
                  dc_in   = '0;
                  bad_in  = 1'b0;
               end else begin
                  cmd.a_valid = 1'b1;
                  cmd.a_cp    = flush_cp;
                  run_esc     = 1'b1;
               end
            end
            jsu_pkg::MODE_LOW_HEX: begin
               acc_in = acc_t;
               dc_in  = dc_t;
               bad_in = bad_t;
               if (dc_t >= 3'd4) begin
                  if (!bad_t && acc_t >= jsu_pkg::LOW_SURR_LO &&
                      acc_t <= jsu_pkg::LOW_SURR_HI) begin
                     // surrogate pair becomes one supplementary code point
                     cmd.a_valid = 1'b1;
                     cmd.a_cp    = jsu_pkg::SUPP_BASE +
                                   jsu_pkg::CP_WIDTH'({high_ff, acc_t[9:0]});
                     mode_in     = jsu_pkg::MODE_PLAIN;
                     acc_in      = '0;
                     dc_in       = '0;
                     bad_in      = 1'b0;
                  end else begin
                     // no low partner: emit the high one, retry digits alone
                     cmd.a_valid  = 1'b1;
                     cmd.a_cp     = flush_cp;
                     run_hex_done = 1'b1;
                  end
               end
            end
            default: run_plain = 1'b1;
         endcase
      end

      if (run_plain) begin
         mode_in = jsu_pkg::MODE_PLAIN;
         if (c == CHAR_QUOTE) begin
            finish     = 1'b1;
            fin_status = jsu_pkg::STATUS_OK;
         end else if (c == CHAR_BSLASH) begin
            mode_in = jsu_pkg::MODE_ESC;
         end else if (c < CHAR_SPACE) begin
            finish     = 1'b1;
            fin_status = jsu_pkg::STATUS_CONTROL;
         end else begin
            cmd.b_valid = 1'b1;
            cmd.b_raw   = 1'b1;
            cmd.b_cp    = jsu_pkg::CP_WIDTH'(c);
         end
      end

      if (run_esc) begin
         mode_in = jsu_pkg::MODE_PLAIN;
         case (c) inside
            CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: begin
               cmd.b_valid = 1'b1;
               cmd.b_cp    = jsu_pkg::CP_WIDTH'(c);
            end
            CHAR_B: begin
               cmd.b_valid = 1'b1;
               cmd.b_cp    = 21'h08;
            end
            CHAR_F: begin
               cmd.b_valid = 1'b1;
               cmd.b_cp    = 21'h0C;
            end
            CHAR_N: begin
               cmd.b_valid = 1'b1;
               cmd.b_cp    = 21'h0A;
            end
            CHAR_R: begin
               cmd.b_valid = 1'b1;
               cmd.b_cp    = 21'h0D;
            end
            CHAR_T: begin
               cmd.b_valid = 1'b1;
               cmd.b_cp    = 21'h09;
            end
            CHAR_U: begin
               mode_in = jsu_pkg::MODE_HEX;
               acc_in  = '0;
               dc_in   = '0;
               bad_in  = 1'b0;
            end
            default: begin
               finish     = 1'b1;
               fin_status = jsu_pkg::STATUS_BAD_ESCAPE;
            end
         endcase
      end

      if (run_hex_done) begin
         if (bad_t) begin
            finish     = 1'b1;
            fin_status = jsu_pkg::STATUS_BAD_HEX;
         end else if (acc_t >= jsu_pkg::HIGH_SURR_LO && acc_t <= jsu_pkg::HIGH_SURR_HI) begin
            high_in = acc_t[9:0];
            mode_in = jsu_pkg::MODE_HIGH;
         end else if (acc_t >= jsu_pkg::LOW_SURR_LO && acc_t <= jsu_pkg::LOW_SURR_HI) begin
            finish     = 1'b1;
            fin_status = jsu_pkg::STATUS_LONE_LOW;
         end else begin
            cmd.b_valid = 1'b1;
            cmd.b_cp    = jsu_pkg::CP_WIDTH'(acc_t);
            mode_in     = jsu_pkg::MODE_PLAIN;
         end
      end

      // running length, saturating
      na        = cmd.a_valid ? jsu_pkg::utf8_len(cmd.a_cp) : 3'd0;
      nb        = !cmd.b_valid ? 3'd0 : (cmd.b_raw ? 3'd1 : jsu_pkg::utf8_len(cmd.b_cp));
      sum       = (LW+3)'(count_ff) + (LW+3)'(na) + (LW+3)'(nb);
      sat_count = (sum > COUNT_MAX) ? {LW{1'b1}} : sum[LW-1:0];
      sat_wide  = 32'(sat_count);
      count_in  = sat_count;

      if (finish) begin
         cmd.done   = 1'b1;
         cmd.status = fin_status;
         cmd.length = (sat_wide > 32'hFFFF) ? 16'hFFFF : sat_wide[15:0];
         mode_in    = jsu_pkg::MODE_PLAIN;
         acc_in     = '0;
         dc_in      = '0;
         bad_in     = 1'b0;
         high_in    = '0;
         count_in   = '0;
      end

      cmd_valid = accept & (cmd.a_valid | cmd.b_valid | cmd.done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= jsu_pkg::MODE_PLAIN;
         acc_ff   <= '0;
         dc_ff    <= '0;
         bad_ff   <= 1'b0;
         high_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         dc_ff    <= dc_in;
         bad_ff   <= bad_in;
         high_ff  <= high_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/jsu_cmd_queue.sv]
// ----------------------------------------------------------------------------
// jsu_cmd_queue: command queue
// Short register queue between the decoder and the byte sequencer, so that
// either side can stall without holding the other.
// ----------------------------------------------------------------------------
module jsu_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output jsu_pkg::cmd_type head,
   output logic             empty
);

   localparam int AW = jsu_pkg::QUEUE_AW;
   localparam int CW = jsu_pkg::QUEUE_CW;
   localparam logic [AW-1:0] LAST_SLOT = AW'(jsu_pkg::QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(jsu_pkg::QUEUE_DEPTH);

   jsu_pkg::cmd_type entries_ff [jsu_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[rtl/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back: byte sequencer
// Walks the command at the queue head one result per cycle while not stalled:
// UTF-8 bytes of the first code point, then of the second, then any done record.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::cmd_type head,
   input  logic             head_valid,
   output logic             head_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output jsu_pkg::rsp_type rsp_data
);

   jsu_pkg::rsp_type out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  idx_ff, idx_in;
   logic [2:0]  na, nb, k;
   logic [3:0]  total;
   logic        advance, is_last;

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      na      = head.a_valid ? jsu_pkg::utf8_len(head.a_cp) : 3'd0;
      nb      = !head.b_valid ? 3'd0 : (head.b_raw ? 3'd1 : jsu_pkg::utf8_len(head.b_cp));
      total   = 4'(na) + 4'(nb) + 4'(head.done);
      is_last = ({1'b0, idx_ff} + 4'd1 == total);
      k       = idx_ff - na;
      advance = head_valid & (~out_valid_ff | rsp_pop);

      out_in      = '0;
      out_in.last = is_last;
      if (idx_ff < na) begin
         out_in.out_byte   = jsu_pkg::utf8_byte(head.a_cp, na, idx_ff);
         out_in.byte_valid = 1'b1;
      end else if ({1'b0, idx_ff} < 4'(na) + 4'(nb)) begin
         out_in.out_byte   = jsu_pkg::utf8_byte(head.b_cp, nb, k);
         out_in.byte_valid = 1'b1;
      end else begin
         out_in.string_done    = 1'b1;
         out_in.status         = head.status;
         out_in.decoded_length = head.length;
      end

      head_pop     = advance & is_last;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         idx_in       = is_last ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end

endmodule

[rtl/json_string_unescape.sv]
// ----------------------------------------------------------------------------
// json_string_unescape: streaming JSON string unescaper
// Takes string content bytes and returns the unescaped UTF-8 bytes followed
// by a done record with status and decoded length.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive req_data and raise req_push; the
//   beat is taken on an edge where req_full is low. Each beat is one content
//   byte, or an end-of-input marker.
//   Result side is a queue read port: while rsp_empty is low, rsp_data holds
//   the oldest result; raise rsp_pop to take it. The last result caused by
//   an input beat has last set; a string ends with a done record.
//   A beat's results pass through the command queue and the output register
//   on their way to the port.
//   Throughput: one input beat per cycle while req_full is low. The result
//   port moves one beat per cycle while rsp_pop is high, so a beat with
//   several results (a \u escape gives up to six) holds the sequencer, but a
//   four-entry command queue lets input go on; req_full rises once it fills.
//   When the receiver stalls, results wait in the output register and the
//   queue; nothing is dropped.
//   Reset clears the decoder to plain content, empties the queue and the
//   output register; the block is ready on the cycle after reset.
// ----------------------------------------------------------------------------
module json_string_unescape (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  jsu_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output jsu_pkg::rsp_type rsp_data
);

   jsu_pkg::cmd_type cmd, head;
   logic cmd_valid, head_valid, head_pop, q_empty, accept;

   assign accept     = req_push & ~req_full;
   assign head_valid = ~q_empty;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cmd       (cmd),
      .cmd_valid (cmd_valid)
   );

   jsu_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_data (cmd),
      .full      (req_full),
      .pop       (head_pop),
      .head      (head),
      .empty     (q_empty)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   // a done record always closes the results of its beat
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.string_done |-> rsp_data.last)
      else $error("done record without last");

   // every result is either a byte or a done record
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.byte_valid ^ rsp_data.string_done))
      else $error("result is neither byte nor done");

   // after reset nothing is pending and input is open
   assert property (@(posedge clock) !reset && $past(reset) |-> rsp_empty && !req_full)
      else $error("block not clear after reset");

   // the sequencer only retires a command that exists
   assert property (@(posedge clock) disable iff (reset) head_pop |-> head_valid)
      else $error("command retired from empty queue");

endmodule

[tb/json_string_unescape_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_tb: self-checking bench for the JSON string unescaper
// A short table of directed beats comes first. Random strings follow: plain
// bytes, escapes, \u escapes and surrogate pairs, closed by quotes or by
// errors, with noise mixed in. A decoder model inside the bench predicts
// every result, and both ports stall at random except in the closing part.
// ----------------------------------------------------------------------------
module json_string_unescape_tb;

   localparam int RANDOM_BEATS      = 190;
   localparam int TAIL_BEATS        = 40;
   localparam int DRAIN_CYCLES      = 16;
   localparam int CYCLE_LIMIT       = 400000;
   localparam int REPORT_CAP        = 40;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   typedef struct packed {
      logic [7:0]          data;
      logic                eoi;
      logic                typed;
      jsu_pkg::status_type want;
   } table_row_type;

   typedef struct {
      jsu_pkg::req_type    beat;
      bit                  typed;
      jsu_pkg::status_type want;
   } stim_row_type;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             req_push = 1'b0;
   jsu_pkg::req_type req_data = '0;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop  = 1'b0;
   jsu_pkg::rsp_type rsp_data;

   // decoder model state
   jsu_pkg::mode_type   dec_mode;
   logic [15:0]         hex_acc;
   logic [2:0]          hex_digits;
   bit                  hex_bad;
   logic [9:0]          held_high;
   logic [15:0]         out_count;
   bit                  step_closed;
   jsu_pkg::status_type step_status;

   jsu_pkg::rsp_type decoded_queue[$];
   stim_row_type     stim[$];
   table_row_type    dir_table [28];
   bit               allow_idle  = 1'b1;
   int               errors      = 0;
   int               pop_hold    = 0;
   int               cycle_count = 0;

   json_string_unescape dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------------
   function automatic void clear_decoder();
      dec_mode   = jsu_pkg::MODE_PLAIN;
      hex_acc    = '0;
      hex_digits = '0;
      hex_bad    = 1'b0;
      held_high  = '0;
      out_count  = '0;
   endfunction

   function automatic void add_result(logic [7:0] b, logic valid, logic done,
                                      jsu_pkg::status_type st, logic [15:0] len);
      jsu_pkg::rsp_type r;
      r.out_byte       = b;
      r.byte_valid     = valid;
      r.string_done    = done;
      r.status         = st;
      r.decoded_length = len;
      r.last           = 1'b0;
      decoded_queue.push_back(r);
   endfunction

   function automatic void emit_byte(logic [7:0] b);
      add_result(b, 1'b1, 1'b0, jsu_pkg::STATUS_OK, '0);
      if (out_count != 16'hFFFF) out_count++;
   endfunction

   function automatic void close_string(jsu_pkg::status_type st);
      add_result('0, 1'b0, 1'b1, st, out_count);
      step_closed = 1'b1;
      step_status = st;
      clear_decoder();
   endfunction

   function automatic void put_code(logic [20:0] cp);
      if (cp <= 21'h7F) begin
         emit_byte(cp[7:0]);
      end else if (cp <= 21'h7FF) begin
         emit_byte({3'b110, cp[10:6]});
         emit_byte({2'b10, cp[5:0]});
      end else if (cp <= 21'hFFFF) begin
         emit_byte({4'b1110, cp[15:12]});
         emit_byte({2'b10, cp[11:6]});
         emit_byte({2'b10, cp[5:0]});
      end else begin
         emit_byte({5'b11110, cp[20:18]});
         emit_byte({2'b10, cp[17:12]});
         emit_byte({2'b10, cp[11:6]});
         emit_byte({2'b10, cp[5:0]});
      end
   endfunction

   function automatic void open_hex(jsu_pkg::mode_type m);
      dec_mode   = m;
      hex_acc    = '0;
      hex_digits = '0;
      hex_bad    = 1'b0;
   endfunction

   function automatic bit is_hex(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic void add_digit(logic [7:0] c);
      logic [3:0] d;
      if (c >= "0" && c <= "9") begin
         d = c[3:0];
      end else if (is_hex(c)) begin
         // letters of either case carry 1..6 in the low nibble
         d = c[3:0] + 4'd9;
      end else begin
         d = '0;
         hex_bad = 1'b1;
      end
      hex_acc = {hex_acc[11:0], d};
      hex_digits++;
   endfunction

   function automatic void flush_held();
      put_code({5'b0, 6'b110110, held_high});
   endfunction

   function automatic void finish_hex();
      if (hex_bad) begin
         close_string(jsu_pkg::STATUS_BAD_HEX);
      end else if (hex_acc >= jsu_pkg::HIGH_SURR_LO && hex_acc <= jsu_pkg::HIGH_SURR_HI) begin
         held_high = hex_acc[9:0];
         dec_mode  = jsu_pkg::MODE_HIGH;
      end else if (hex_acc >= jsu_pkg::LOW_SURR_LO && hex_acc <= jsu_pkg::LOW_SURR_HI) begin
         close_string(jsu_pkg::STATUS_LONE_LOW);
      end else begin
         put_code({5'b0, hex_acc});
         dec_mode = jsu_pkg::MODE_PLAIN;
      end
   endfunction

   function automatic void plain_byte(logic [7:0] c);
      if (c == CH_QUOTE) close_string(jsu_pkg::STATUS_OK);
      else if (c == CH_BSLASH) dec_mode = jsu_pkg::MODE_ESC;
      else if (c < 8'h20) close_string(jsu_pkg::STATUS_CONTROL);
      else emit_byte(c);
   endfunction

   function automatic void esc_byte(logic [7:0] c);
      dec_mode = jsu_pkg::MODE_PLAIN;
      case (c)
         CH_QUOTE:  emit_byte(CH_QUOTE);
         CH_BSLASH: emit_byte(CH_BSLASH);
         "/":       emit_byte("/");
         "b":       emit_byte(8'h08);
         "f":       emit_byte(8'h0C);
         "n":       emit_byte(8'h0A);
         "r":       emit_byte(8'h0D);
         "t":       emit_byte(8'h09);
         CH_U:      open_hex(jsu_pkg::MODE_HEX);
         default:   close_string(jsu_pkg::STATUS_BAD_ESCAPE);
      endcase
   endfunction

   function automatic void unescape_beat(jsu_pkg::req_type beat);
      int               prior_size;
      jsu_pkg::rsp_type tail;
      logic [7:0]       c;
      prior_size  = decoded_queue.size();
      step_closed = 1'b0;
      c = beat.data_byte;
      if (beat.end_of_input) begin
         case (dec_mode)
            jsu_pkg::MODE_ESC:     close_string(jsu_pkg::STATUS_CUT_ESCAPE);
            jsu_pkg::MODE_HEX:     close_string(jsu_pkg::STATUS_CUT_UNICODE);
            jsu_pkg::MODE_HIGH: begin
               flush_held();
               close_string(jsu_pkg::STATUS_UNTERMINATED);
            end
            jsu_pkg::MODE_HIGH_BS: begin
               flush_held();
               close_string(jsu_pkg::STATUS_CUT_ESCAPE);
            end
            jsu_pkg::MODE_LOW_HEX: begin
               flush_held();
               close_string(jsu_pkg::STATUS_CUT_UNICODE);
            end
            default:      close_string(jsu_pkg::STATUS_UNTERMINATED);
         endcase
      end else begin
         case (dec_mode)
            jsu_pkg::MODE_ESC: esc_byte(c);
            jsu_pkg::MODE_HEX: begin
               add_digit(c);
               if (hex_digits == 3'd4) finish_hex();
            end
            jsu_pkg::MODE_HIGH: begin
               if (c == CH_BSLASH) begin
                  dec_mode = jsu_pkg::MODE_HIGH_BS;
               end else begin
                  flush_held();
                  dec_mode = jsu_pkg::MODE_PLAIN;
                  plain_byte(c);
               end
            end
            jsu_pkg::MODE_HIGH_BS: begin
               if (c == CH_U) begin
                  open_hex(jsu_pkg::MODE_LOW_HEX);
               end else begin
                  flush_held();
                  esc_byte(c);
               end
            end
            jsu_pkg::MODE_LOW_HEX: begin
               add_digit(c);
               if (hex_digits == 3'd4) begin
                  if (!hex_bad && hex_acc >= jsu_pkg::LOW_SURR_LO &&
                      hex_acc <= jsu_pkg::LOW_SURR_HI) begin
                     put_code(21'h10000 + {held_high, hex_acc[9:0]});
                     open_hex(jsu_pkg::MODE_PLAIN);
                  end else begin
                     // partner failed: emit the held half, retry digits as a fresh escape
                     flush_held();
                     dec_mode = jsu_pkg::MODE_HEX;
                     finish_hex();
                  end
               end
            end
            default: begin
               dec_mode = jsu_pkg::MODE_PLAIN;
               plain_byte(c);
            end
         endcase
      end
      if (decoded_queue.size() > prior_size) begin
         tail = decoded_queue.pop_back();
         tail.last = 1'b1;
         decoded_queue.push_back(tail);
      end
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   function automatic void report_mismatch(string field, logic [15:0] want,
                                           logic [15:0] got);
      if (errors < REPORT_CAP)
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      errors++;
   endfunction

   function automatic void check_result(jsu_pkg::rsp_type got);
      jsu_pkg::rsp_type want;
      if (decoded_queue.size() == 0) begin
         if (errors < REPORT_CAP)
            $display("%0t: unexpected result, expected none actual %h", $time, got);
         errors++;
      end else begin
         want = decoded_queue.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", 16'(want.out_byte), 16'(got.out_byte));
         if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
         if (got.string_done !== want.string_done)
            report_mismatch("string_done", 16'(want.string_done), 16'(got.string_done));
         if (got.status !== want.status)
            report_mismatch("status", 16'(want.status), 16'(got.status));
         if (got.decoded_length !== want.decoded_length)
            report_mismatch("decoded_length", want.decoded_length, got.decoded_length);
         if (got.last !== want.last)
            report_mismatch("last", 16'(want.last), 16'(got.last));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result(rsp_data);
         if (pop_hold == 0 && allow_idle && $urandom_range(0, 7) == 0)
            pop_hold = $urandom_range(1, 3);
         if (pop_hold > 0) begin
            rsp_pop <= 1'b0;
            pop_hold--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic void add_beat(logic [7:0] c);
      stim_row_type r;
      r.beat.data_byte    = c;
      r.beat.end_of_input = 1'b0;
      r.typed             = 1'b0;
      r.want              = jsu_pkg::STATUS_OK;
      stim.push_back(r);
   endfunction

   function automatic void add_end();
      stim_row_type r;
      r.beat.data_byte    = 8'($urandom_range(0, 255));
      r.beat.end_of_input = 1'b1;
      r.typed             = 1'b0;
      r.want              = jsu_pkg::STATUS_OK;
      stim.push_back(r);
   endfunction

   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      c = 8'($urandom_range(8'h20, 8'hFF));
      while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(8'h20, 8'hFF));
      return c;
   endfunction

   function automatic logic [7:0] esc_char();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0:       c = CH_QUOTE;
         1:       c = CH_BSLASH;
         2:       c = "/";
         3:       c = "b";
         4:       c = "f";
         5:       c = "n";
         6:       c = "r";
         default: c = "t";
      endcase
      return c;
   endfunction

   // 0: one byte, 1: two bytes, 2: three bytes, 3: high half, 4: low half
   function automatic logic [15:0] pick_code(int cls);
      logic [15:0] v;
      case (cls)
         0:       v = 16'($urandom_range(16'h0000, 16'h007F));
         1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
         2:       v = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                           : 16'($urandom_range(16'hE000, 16'hFFFF));
         3:       v = 16'($urandom_range(jsu_pkg::HIGH_SURR_LO, jsu_pkg::HIGH_SURR_HI));
         default: v = 16'($urandom_range(jsu_pkg::LOW_SURR_LO, jsu_pkg::LOW_SURR_HI));
      endcase
      return v;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return "0" + 8'(n);
      return ($urandom_range(0, 1) ? "A" : "a") + 8'(n) - 8'd10;
   endfunction

   // quotes and backslashes are taken as digits too, so favor them
   function automatic logic [7:0] non_hex();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0: c = CH_QUOTE;
         1: c = CH_BSLASH;
         default: begin
            c = 8'($urandom_range(0, 255));
            while (is_hex(c)) c = 8'($urandom_range(0, 255));
         end
      endcase
      return c;
   endfunction

   function automatic void add_unicode(logic [15:0] value, bit with_bad);
      int bad_at;
      bad_at = with_bad ? $urandom_range(0, 3) : 4;
      add_beat(CH_BSLASH);
      add_beat(CH_U);
      for (int k = 3; k >= 0; k--)
         add_beat(k == bad_at ? non_hex() : hex_char(value[4*k +: 4]));
   endfunction

   function automatic void add_token();
      case ($urandom_range(0, 9))
         0, 1, 2: add_beat(pick_plain());
         3, 4: begin
            add_beat(CH_BSLASH);
            add_beat(esc_char());
         end
         5: add_unicode(pick_code($urandom_range(0, 2)), 1'b0);
         6: begin
            add_unicode(pick_code(3), 1'b0);
            add_unicode(pick_code(4), 1'b0);
         end
         7: begin
            // high half whose partner never shows up
            add_unicode(pick_code(3), 1'b0);
            case ($urandom_range(0, 3))
               0: add_beat(pick_plain());
               1: begin
                  add_beat(CH_BSLASH);
                  add_beat($urandom_range(0, 1) ? esc_char() : pick_plain());
               end
               2: add_unicode(pick_code($urandom_range(0, 3)), 1'b0);
               default: add_unicode(pick_code(4), 1'b1);
            endcase
         end
         8: add_unicode(pick_code($urandom_range(0, 4)), $urandom_range(0, 3) == 0);
         default: add_beat($urandom_range(0, 1) ? 8'hFF : 8'h20);
      endcase
   endfunction

   function automatic void add_closer();
      case ($urandom_range(0, 11))
         7: add_beat(8'($urandom_range(0, 31)));
         8: begin
            add_beat(CH_BSLASH);
            add_beat(8'($urandom_range(0, 255)));
         end
         9: add_end();
         10: begin
            add_beat(CH_BSLASH);
            add_end();
         end
         11: begin
            // input cut short inside an escape or after a held high half
            case ($urandom_range(0, 3))
               0: begin
                  add_beat(CH_BSLASH);
                  add_beat(CH_U);
               end
               1: add_unicode(pick_code(3), 1'b0);
               2: begin
                  add_unicode(pick_code(3), 1'b0);
                  add_beat(CH_BSLASH);
               end
               default: begin
                  add_unicode(pick_code(3), 1'b0);
                  add_beat(CH_BSLASH);
                  add_beat(CH_U);
               end
            endcase
            repeat ($urandom_range(0, 3)) add_beat(hex_char(4'($urandom_range(0, 15))));
            add_end();
         end
         default: add_beat(CH_QUOTE);
      endcase
   endfunction

   function automatic void add_strings(int count);
      int stop;
      stop = stim.size() + count;
      while (stim.size() < stop) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 11) == 0) add_end();
               else add_beat(8'($urandom_range(0, 255)));
            end
         end else begin
            repeat ($urandom_range(1, 6)) add_token();
            add_closer();
         end
      end
   endfunction

   task automatic send_beat(input stim_row_type row);
      req_data <= row.beat;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      unescape_beat(row.beat);
      if (row.typed && (!step_closed || step_status != row.want))
         report_mismatch("status", 16'(row.want), 16'(step_status));
   endtask

   task automatic drive_stim();
      stim_row_type row;
      while (stim.size() > 0) begin
         row = stim.pop_front();
         if (allow_idle && $urandom_range(0, 7) == 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         send_beat(row);
      end
   endtask

   task automatic pause_until_drained();
      req_push <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
   endtask

   initial begin
      stim_row_type row;
      clear_decoder();
      dir_table = '{
         '{"A",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{8'hFF,     1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{8'h20,     1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{CH_QUOTE,  1'b0, 1'b1, jsu_pkg::STATUS_OK},
         '{8'h00,     1'b0, 1'b1, jsu_pkg::STATUS_CONTROL},
         '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"t",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         // high half, then its low partner
         '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{CH_U,      1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"D",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"8",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"3",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"d",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{CH_U,      1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"D",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"E",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"0",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"0",       1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{8'h00,     1'b1, 1'b1, jsu_pkg::STATUS_UNTERMINATED},
         '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{"q",       1'b0, 1'b1, jsu_pkg::STATUS_BAD_ESCAPE},
         '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{8'hFF,     1'b1, 1'b1, jsu_pkg::STATUS_CUT_ESCAPE},
         // a quote inside \u is just a digit
         '{CH_BSLASH, 1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{CH_U,      1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{CH_QUOTE,  1'b0, 1'b0, jsu_pkg::STATUS_OK},
         '{8'h00,     1'b1, 1'b1, jsu_pkg::STATUS_CUT_UNICODE}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         row.beat.data_byte    = dir_table[i].data;
         row.beat.end_of_input = dir_table[i].eoi;
         row.typed             = dir_table[i].typed;
         row.want              = dir_table[i].want;
         stim.push_back(row);
      end
      drive_stim();
      pause_until_drained();

      add_strings(RANDOM_BEATS);
      drive_stim();

      // closing part: no gaps on either side
      allow_idle = 1'b0;
      add_strings(TAIL_BEATS);
      drive_stim();
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

[sim.f]
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_cmd_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape.sv
tb/json_string_unescape_tb.sv
